### sv/rbsf_pkg.sv
`default_nettype none
package rbsf_pkg;

  // largest frame the line stores are sized for
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int DIM_W = 11;
  localparam int CHAN_W = 8;
  localparam int PIX_W = 3 * CHAN_W;
  localparam int SUM_W = 12;

  // reciprocal of 9 in 15 fractional bits, exact for sums up to 9 * 255
  localparam int RECIP_SHIFT = 15;
  localparam logic [SUM_W-1:0] RECIP_NINE = SUM_W'(3641);

  // configuration register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic MODE_BLUR    = 1'b0;
  localparam logic MODE_SHARPEN = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              frame_done;
  } pix_out_t;

  // one column of the 3x3 window, top row first
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  typedef col_t [2:0] win_t;

  // handshake and tag of a window on its way to the kernel
  typedef struct packed {
    logic valid;
    logic last;
  } win_ctl_t;

endpackage
`default_nettype wire

### sv/rbsf_line_ram.sv
`default_nettype none
module rbsf_line_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 48
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### sv/rbsf_col_cell.sv
`default_nettype none
module rbsf_col_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           shift,
  input  wire rbsf_pkg::col_t col_in,
  output rbsf_pkg::col_t      col
);

  // one window column, takes its right neighbor on every shift
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (shift) begin
      col <= col_in;
    end
  end

endmodule
`default_nettype wire

### sv/rbsf_kernel.sv
`default_nettype none
module rbsf_kernel (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               mode,
  input  wire rbsf_pkg::win_ctl_t win_ctl,
  input  wire rbsf_pkg::win_t     win,
  output logic                    win_ready,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output rbsf_pkg::pix_out_t      res_data
);

  typedef logic [rbsf_pkg::SUM_W-1:0] sum_t;
  typedef logic [rbsf_pkg::CHAN_W-1:0] chan_t;

  // sum stage
  logic  s3_valid;
  logic  s3_last;
  sum_t  s3_sum [3];
  chan_t s3_ctr [3];
  logic  out_ready;
  sum_t  sum_next [3];

  assign out_ready = !res_valid || !res_stall;
  assign win_ready = !s3_valid || out_ready;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_next[ch] = '0;
      for (int k = 0; k < 3; k++) begin
        sum_next[ch] = sum_next[ch]
          + sum_t'(win[k].top[ch*rbsf_pkg::CHAN_W +: rbsf_pkg::CHAN_W])
          + sum_t'(win[k].mid[ch*rbsf_pkg::CHAN_W +: rbsf_pkg::CHAN_W])
          + sum_t'(win[k].bot[ch*rbsf_pkg::CHAN_W +: rbsf_pkg::CHAN_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (win_ready) begin
      s3_valid <= win_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (win_ready) begin
      s3_last <= win_ctl.last;
      for (int ch = 0; ch < 3; ch++) begin
        s3_sum[ch] <= sum_next[ch];
        s3_ctr[ch] <= win[1].mid[ch*rbsf_pkg::CHAN_W +: rbsf_pkg::CHAN_W];
      end
    end
  end

  // divide or clamp stage
  chan_t res_ch [3];

  always_comb begin
    logic [2*rbsf_pkg::SUM_W-1:0] prod;
    logic signed [rbsf_pkg::SUM_W:0] diff;
    for (int ch = 0; ch < 3; ch++) begin
      prod = {{rbsf_pkg::SUM_W{1'b0}}, s3_sum[ch]}
           * {{rbsf_pkg::SUM_W{1'b0}}, rbsf_pkg::RECIP_NINE};
      // 10 * centre minus the full sum, same as 9 * centre minus neighbors
      diff = $signed({1'b0, sum_t'({s3_ctr[ch], 3'b000}) + sum_t'({s3_ctr[ch], 1'b0})})
           - $signed({1'b0, s3_sum[ch]});
      if (mode == rbsf_pkg::MODE_BLUR) begin
        res_ch[ch] = prod[rbsf_pkg::RECIP_SHIFT +: rbsf_pkg::CHAN_W];
      end else if (diff < 0) begin
        res_ch[ch] = '0;
      end else if (diff > 255) begin
        res_ch[ch] = '1;
      end else begin
        res_ch[ch] = diff[rbsf_pkg::CHAN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_ready) begin
      res_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      res_data.red_out    <= res_ch[2];
      res_data.green_out  <= res_ch[1];
      res_data.blue_out   <= res_ch[0];
      res_data.frame_done <= s3_last;
    end
  end

endmodule
`default_nettype wire

### sv/rgb_3x3_blur_sharpen_filter_top.sv
`default_nettype none
// channel   ports                                   transfer when
// pixel     pix_valid, pix_stall, pix_data          pix_valid & !pix_stall
// result    res_valid, res_stall, res_data          res_valid & !res_stall
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid & cfg_ready
//
// one pixel per cycle sustained while results are not stalled; a result follows the
// transfer of the pixel that completes its window through the line store read at
// that transfer, then window shift, sum, divide/clamp
// the line store is one dual-port ram holding both previous rows per column
// reset clears counters, window and pipeline valids and restores config defaults; line stores keep contents
// a stalled result backs up stage by stage, bubbles are squeezed out first
module rgb_3x3_blur_sharpen_filter_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          pix_valid,
  output logic                               pix_stall,
  input  wire rbsf_pkg::pix_in_t             pix_data,
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output rbsf_pkg::pix_out_t                 res_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [rbsf_pkg::DIM_W-1:0]    cfg_data
);

  typedef logic [rbsf_pkg::COL_W-1:0] col_idx_t;
  typedef logic [rbsf_pkg::ROW_W-1:0] row_idx_t;
  typedef logic [rbsf_pkg::DIM_W-1:0] dim_t;

  // configuration registers
  logic mode;
  dim_t width_reg;
  dim_t height_reg;
  logic cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // sizes in use, saturated to 3..max
  dim_t wdim;
  dim_t hdim;

  always_comb begin
    if (width_reg < dim_t'(3)) begin
      wdim = dim_t'(3);
    end else if (width_reg > dim_t'(rbsf_pkg::MAX_WIDTH)) begin
      wdim = dim_t'(rbsf_pkg::MAX_WIDTH);
    end else begin
      wdim = width_reg;
    end
    if (height_reg < dim_t'(3)) begin
      hdim = dim_t'(3);
    end else if (height_reg > dim_t'(rbsf_pkg::MAX_HEIGHT)) begin
      hdim = dim_t'(rbsf_pkg::MAX_HEIGHT);
    end else begin
      hdim = height_reg;
    end
  end

  // raster position of the next pixel
  col_idx_t col_cnt;
  row_idx_t row_cnt;
  logic     col_end;
  logic     row_end;
  logic     pix_xfer;

  assign col_end  = dim_t'(col_cnt) == wdim - dim_t'(1);
  assign row_end  = dim_t'(row_cnt) == hdim - dim_t'(1);
  assign pix_xfer = pix_valid && !pix_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= rbsf_pkg::MODE_BLUR;
      width_reg  <= dim_t'(rbsf_pkg::MAX_WIDTH);
      height_reg <= dim_t'(rbsf_pkg::MAX_HEIGHT);
      col_cnt    <= '0;
      row_cnt    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        rbsf_pkg::REG_MODE: begin
          mode <= cfg_data[0];
        end
        rbsf_pkg::REG_WIDTH: begin
          width_reg <= cfg_data;
          col_cnt   <= '0;
          row_cnt   <= '0;
        end
        rbsf_pkg::REG_HEIGHT: begin
          height_reg <= cfg_data;
          col_cnt    <= '0;
          row_cnt    <= '0;
        end
        default: begin
          // unknown register, write dropped
        end
      endcase
    end else if (pix_xfer) begin
      if (col_end) begin
        col_cnt <= '0;
        row_cnt <= row_end ? '0 : row_cnt + row_idx_t'(1);
      end else begin
        col_cnt <= col_cnt + col_idx_t'(1);
      end
    end
  end

  // stage 1: pixel waits here while the line store read completes
  logic             s1_valid;
  logic             s1_emit;
  logic             s1_last;
  rbsf_pkg::pix_t   s1_pix;
  col_idx_t         s1_col;
  logic             s1_go;
  logic             win_load_ok;
  logic [2*rbsf_pkg::PIX_W-1:0] line_rd;

  assign s1_go     = s1_valid && win_load_ok;
  assign pix_stall = s1_valid && !win_load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_xfer) begin
      s1_pix  <= pix_data;
      s1_col  <= col_cnt;
      // window is complete once two rows and two columns are in
      s1_emit <= (row_cnt >= row_idx_t'(2)) && (col_cnt >= col_idx_t'(2));
      s1_last <= row_end && col_end;
    end
  end

  // upper row in the high half, middle row in the low half; a pixel pushes the
  // middle row up and takes its place
  rbsf_line_ram #(
    .DEPTH  (rbsf_pkg::MAX_WIDTH),
    .ADDR_W (rbsf_pkg::COL_W),
    .DATA_W (2 * rbsf_pkg::PIX_W)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_col),
    .wdata ({line_rd[rbsf_pkg::PIX_W-1:0], s1_pix}),
    .re    (pix_xfer),
    .raddr (col_cnt),
    .rdata (line_rd)
  );

  // stage 2: the 3x3 window as a row of column cells shifting left
  rbsf_pkg::win_t     win;
  rbsf_pkg::col_t     new_col;
  rbsf_pkg::win_ctl_t win_ctl;
  logic               kern_ready;

  assign new_col.top = line_rd[2*rbsf_pkg::PIX_W-1:rbsf_pkg::PIX_W];
  assign new_col.mid = line_rd[rbsf_pkg::PIX_W-1:0];
  assign new_col.bot = s1_pix;

  // the window may shift only once the kernel has taken the one it holds
  assign win_load_ok = !win_ctl.valid || kern_ready;

  for (genvar k = 0; k < 3; k++) begin : g_cell
    rbsf_col_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .shift  (s1_go),
      .col_in ((k == 2) ? new_col : win[(k + 1) % 3]),
      .col    (win[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_ctl <= '0;
    end else if (s1_go) begin
      win_ctl.valid <= s1_emit;
      win_ctl.last  <= s1_last;
    end else if (kern_ready) begin
      win_ctl.valid <= 1'b0;
    end
  end

  // stages 3 and 4: channel sums, then divide by nine or sharpen and clamp
  rbsf_kernel u_kernel (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .win_ctl   (win_ctl),
    .win       (win),
    .win_ready (kern_ready),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule
`default_nettype wire

### sim/tb_top.sv
module tb_top;
  import rbsf_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 4;
  // results trail their pixel, leave some margin before a config write
  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_IDLE       = 16;
  localparam int MAX_PRINTED    = 100;
  localparam int TIMEOUT_CYCLES = 1_500_000;
  localparam int RANDOM_ITEMS   = 420;
  localparam int PHASE_ITEMS    = 120;
  localparam int WIDE_ITEMS     = 40;
  localparam int TALL_ITEMS     = 60;
  localparam int KERNEL_TAPS    = 9;
  localparam int CHAN_MAX       = 255;

  // index with no register behind it, a write there must change nothing
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // pixel channel, driven by the testbench
  logic             pix_valid = 1'b0;
  logic             pix_stall;
  pix_in_t          pix_data  = '0;
  // result channel, stalled by the testbench
  logic             res_valid;
  logic             res_stall = 1'b0;
  pix_out_t         res_data;
  // config write channel
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = REG_MODE;
  logic [DIM_W-1:0] cfg_data  = '0;

  rgb_3x3_blur_sharpen_filter_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_data  (pix_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------
  // filter prediction: own copy of registers, line stores, window, counters
  // ---------------------------------------------------------------------
  logic             sharpen_sel = MODE_BLUR;
  logic [DIM_W-1:0] width_reg   = DIM_W'(MAX_WIDTH);
  logic [DIM_W-1:0] height_reg  = DIM_W'(MAX_HEIGHT);
  pix_t             older_row [MAX_WIDTH];   // row r-2 per column
  pix_t             newer_row [MAX_WIDTH];   // row r-1 per column
  pix_t             nbhd [3][3];             // [row][column], column 2 newest
  int               col_pos = 0;
  int               row_pos = 0;

  // pixels waiting to be sent, filtered pixels waiting to come out
  pix_in_t          source_q [$];
  pix_out_t         filtered_q [$];

  int               queued_total   = 0;
  int               accepted_total = 0;
  int               mismatches     = 0;

  // transfer flags from the last rising edge, read by the falling-edge drivers
  logic             pix_took = 1'b0;
  logic             res_took = 1'b0;
  logic             cfg_took = 1'b0;

  // idling knobs, changed per phase so some stretches run back to back
  bit               send_idling = 1'b1;
  bit               recv_idling = 1'b1;
  int               send_wait   = 0;
  int               stall_left  = 0;
  int               stall_draw;

  // untouched line store entries read as zero; they never reach a result
  initial begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      older_row[i] = '0;
      newer_row[i] = '0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        nbhd[i][j] = '0;
  end

  // saturate a frame dimension to the range the block supports
  function automatic int eff_dim(input logic [DIM_W-1:0] v, input int hi);
    if (int'(v) < 3) return 3;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  // one channel of the current window, blur or sharpen
  function automatic logic [CHAN_W-1:0] kernel_chan(input int sh);
    int total;
    int centre;
    int v;
    total = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        total += int'(nbhd[i][j][sh +: CHAN_W]);
    centre = int'(nbhd[1][1][sh +: CHAN_W]);
    if (sharpen_sel == MODE_BLUR) return CHAN_W'(total / KERNEL_TAPS);
    // 9 * centre minus the eight neighbours
    v = (KERNEL_TAPS + 1) * centre - total;
    if (v < 0) v = 0;
    if (v > CHAN_MAX) v = CHAN_MAX;
    return CHAN_W'(v);
  endfunction

  // shift one accepted pixel into the window and queue what it completes
  task automatic convolve_pixel(input pix_in_t p);
    int       w;
    int       h;
    int       idx;
    pix_out_t o;
    w   = eff_dim(width_reg, MAX_WIDTH);
    h   = eff_dim(height_reg, MAX_HEIGHT);
    idx = (col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1;
    for (int i = 0; i < 3; i++) begin
      nbhd[i][0] = nbhd[i][1];
      nbhd[i][1] = nbhd[i][2];
    end
    nbhd[0][2]     = older_row[idx];
    nbhd[1][2]     = newer_row[idx];
    nbhd[2][2]     = p;
    older_row[idx] = newer_row[idx];
    newer_row[idx] = p;
    // window centre is one row up and one column left of this pixel
    if (row_pos >= 2 && col_pos >= 2) begin
      o.red_out    = kernel_chan(2 * CHAN_W);
      o.green_out  = kernel_chan(CHAN_W);
      o.blue_out   = kernel_chan(0);
      o.frame_done = (row_pos == h - 1 && col_pos == w - 1);
      filtered_q.push_back(o);
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // a width or height write restarts the frame, line stores keep contents
  task automatic apply_cfg(input logic [1:0] idx, input logic [DIM_W-1:0] val);
    case (idx)
      REG_MODE: sharpen_sel = val[0];
      REG_WIDTH: begin
        width_reg = val;
        col_pos   = 0;
        row_pos   = 0;
      end
      REG_HEIGHT: begin
        height_reg = val;
        col_pos    = 0;
        row_pos    = 0;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_filtered(input pix_out_t got);
    pix_out_t want;
    if (filtered_q.size() == 0) begin
      report_mismatch($sformatf("result %h with nothing expected", got));
    end else begin
      want = filtered_q.pop_front();
      if (got.red_out !== want.red_out)
        report_mismatch($sformatf("red_out got %h want %h", got.red_out, want.red_out));
      if (got.green_out !== want.green_out)
        report_mismatch($sformatf("green_out got %h want %h", got.green_out,
                                  want.green_out));
      if (got.blue_out !== want.blue_out)
        report_mismatch($sformatf("blue_out got %h want %h", got.blue_out, want.blue_out));
      if (got.frame_done !== want.frame_done)
        report_mismatch($sformatf("frame_done got %b want %b", got.frame_done,
                                  want.frame_done));
    end
  endtask

  // at least half the draws are zero, the rest spread up to the longest wait
  function automatic int draw_idle(input bit enabled);
    if (!enabled || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, MAX_IDLE);
  endfunction

  // ---------------------------------------------------------------------
  // monitor: every transfer is seen at the rising edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    pix_took <= !rst && pix_valid && !pix_stall;
    res_took <= !rst && res_valid && !res_stall;
    cfg_took <= !rst && cfg_valid && cfg_ready;
    if (!rst) begin
      // results leave well after their pixel, so checking first is safe
      if (res_valid && !res_stall) check_filtered(res_data);
      if (pix_valid && !pix_stall) begin
        convolve_pixel(pix_data);
        accepted_total++;
      end
      if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
    end
  end

  // ---------------------------------------------------------------------
  // pixel driver: falling edge, holds a stalled pixel, drawn gap after each transfer
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (!pix_valid || pix_took) begin
      if (send_wait != 0) begin
        pix_valid <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (source_q.size() != 0) begin
        pix_data  <= source_q.pop_front();
        pix_valid <= 1'b1;
        send_wait <= draw_idle(send_idling);
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // result receiver: stall drawn after each result transfer
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (res_took) begin
      stall_draw = draw_idle(recv_idling);
      res_stall  <= (stall_draw != 0);
      stall_left <= (stall_draw == 0) ? 0 : stall_draw - 1;
    end else if (stall_left != 0) begin
      res_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------
  // one register write transfer, valid dropped right after it
  task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_pixel(input pix_in_t p);
    source_q.push_back(p);
    queued_total++;
  endtask

  // every pixel sent, every result in, then room for the pipeline to empty
  task automatic wait_idle();
    do @(negedge clk); while (accepted_total != queued_total || filtered_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // extremes often, so clamps and full-scale sums come up
  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return CHAN_W'($urandom_range(0, CHAN_MAX));
    endcase
  endfunction

  function automatic pix_in_t rand_pixel();
    pix_in_t p;
    p.red_in   = rand_chan();
    p.green_in = rand_chan();
    p.blue_in  = rand_chan();
    return p;
  endfunction

  // mostly small frames, sometimes below the minimum, sometimes wider
  function automatic logic [DIM_W-1:0] rand_dim();
    case ($urandom_range(0, 9))
      0:       return DIM_W'($urandom_range(0, 2));
      1:       return DIM_W'($urandom_range(11, 40));
      default: return DIM_W'($urandom_range(3, 10));
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int               n;
    int               first_part;
    int               phase;
    int               random_items;
    int               cur_w;
    int               cur_h;
    int               sel;
    logic [DIM_W-1:0] dim;
    pix_in_t          p;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // directed: 3x3 frames, a single interior pixel each, frame_done on it
    write_reg(REG_WIDTH, DIM_W'(3));
    write_reg(REG_HEIGHT, DIM_W'(3));
    // full scale everywhere, blur stays at 255
    for (int k = 0; k < 9; k++) queue_pixel({8'hFF, 8'hFF, 8'hFF});
    // second frame right after the wrap: zero red, dark centre green, ramp blue
    for (int k = 0; k < 9; k++) begin
      p.red_in   = '0;
      p.green_in = (k == 4) ? 8'h00 : 8'hFF;
      p.blue_in  = CHAN_W'(k * 30);
      queue_pixel(p);
    end
    wait_idle();
    // only bit 0 of the mode write matters
    write_reg(REG_MODE, {{(DIM_W-1){1'b1}}, MODE_SHARPEN});
    // sharpen: bright centre clamps high, dark centre clamps low, flat stays
    for (int k = 0; k < 9; k++) begin
      p.red_in   = (k == 4) ? 8'hFF : 8'h00;
      p.green_in = (k == 4) ? 8'h00 : 8'hFF;
      p.blue_in  = 8'h40;
      queue_pixel(p);
    end
    wait_idle();

    // random phases: new settings, one or two frames plus up to two rows, capped
    cur_w        = 3;
    cur_h        = 3;
    phase        = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      send_idling = ($urandom_range(0, 3) != 0);
      recv_idling = ($urandom_range(0, 3) != 0);
      // sel 3 keeps the dimensions, so the frame carries on mid-way
      sel = $urandom_range(0, 3);
      if (phase == 0 || sel == 0 || sel == 1) begin
        dim = rand_dim();
        write_reg(REG_WIDTH, dim);
        cur_w = eff_dim(dim, MAX_WIDTH);
      end
      if (phase == 0 || sel == 0 || sel == 2) begin
        dim = rand_dim();
        write_reg(REG_HEIGHT, dim);
        cur_h = eff_dim(dim, MAX_HEIGHT);
      end
      if ($urandom_range(0, 1) != 0) write_reg(REG_MODE, DIM_W'($urandom));
      if ($urandom_range(0, 5) == 0) write_reg(REG_UNMAPPED, DIM_W'($urandom));

      n = cur_w * cur_h * $urandom_range(1, 2) + $urandom_range(0, 2 * cur_w);
      if (n > PHASE_ITEMS) n = PHASE_ITEMS;
      // sometimes hold the sender back until all results are in
      if (phase == 0) first_part = n / 2;
      else if ($urandom_range(0, 3) == 0) first_part = $urandom_range(1, n - 1);
      else first_part = n;
      for (int k = 0; k < first_part; k++) queue_pixel(rand_pixel());
      if (first_part < n) begin
        wait_idle();
        for (int k = first_part; k < n; k++) queue_pixel(rand_pixel());
      end
      wait_idle();
      random_items += n;
      phase++;
    end

    // widest frame: exact maximum first, cut short by a restart
    send_idling = 1'b0;
    recv_idling = 1'b1;
    write_reg(REG_MODE, DIM_W'(MODE_SHARPEN));
    write_reg(REG_WIDTH, DIM_W'(MAX_WIDTH));
    write_reg(REG_HEIGHT, DIM_W'(3));
    for (int k = 0; k < 5; k++) queue_pixel(rand_pixel());
    wait_idle();
    // all ones saturates to the maximum width, a stretch of the first row
    write_reg(REG_WIDTH, '1);
    for (int k = 0; k < WIDE_ITEMS; k++) queue_pixel(rand_pixel());
    wait_idle();

    // tallest frame: exact maximum height, then an oversized one
    send_idling = 1'b1;
    recv_idling = 1'b0;
    write_reg(REG_MODE, DIM_W'(MODE_BLUR));
    write_reg(REG_HEIGHT, DIM_W'(MAX_HEIGHT));
    for (int k = 0; k < 5; k++) queue_pixel(rand_pixel());
    wait_idle();
    // width below the minimum reads as 3, rows run on past any small height
    write_reg(REG_WIDTH, DIM_W'(2));
    write_reg(REG_HEIGHT, '1);
    for (int k = 0; k < TALL_ITEMS; k++) queue_pixel(rand_pixel());
    wait_idle();

    if (mismatches == 0) begin
      $display("PASS rgb_3x3_blur_sharpen_filter_top");
    end else begin
      $display("FAIL rgb_3x3_blur_sharpen_filter_top");
    end
    $finish;
  end

  // hung handshake or lost result
  initial begin : watchdog
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("FAIL rgb_3x3_blur_sharpen_filter_top");
    $finish;
  end

endmodule

### files.f
sv/rbsf_pkg.sv
sv/rbsf_line_ram.sv
sv/rbsf_col_cell.sv
sv/rbsf_kernel.sv
sv/rgb_3x3_blur_sharpen_filter_top.sv
sim/tb_top.sv
